[rtl/dtq_pkg.sv]
`default_nettype none

package dtq_pkg;

  // operation codes of an input beat
  localparam logic [1:0] FUNC_ADD_REL = 2'd0;
  localparam logic [1:0] FUNC_ADD_ABS = 2'd1;
  localparam logic [1:0] FUNC_CANCEL  = 2'd2;
  localparam logic [1:0] FUNC_TICK    = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_PAST      = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  localparam int ID_BITS = 32;

  // most timers that one tick may fire
  localparam int MAX_OUT = 32;
  localparam int KW      = $clog2(MAX_OUT);

  // command broadcast to every cell of one queue
  typedef struct packed {
    logic ins;
    logic del;
  } dtq_cmd_t;

endpackage

`default_nettype wire

[rtl/dtq_in_if.sv]
`default_nettype none

interface dtq_in_if import dtq_pkg::*; #(
  parameter int TIME_BITS = 63
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           func;
  logic                 clock_sel;
  logic [TIME_BITS-1:0] deadline;
  logic [ID_BITS-1:0]   timer_id;
  logic [TIME_BITS-1:0] now_mono;
  logic [TIME_BITS-1:0] now_real;

  modport source (
    output valid, func, clock_sel, deadline, timer_id, now_mono, now_real,
    input  ready
  );
  modport sink (
    input  valid, func, clock_sel, deadline, timer_id, now_mono, now_real,
    output ready
  );
endinterface

`default_nettype wire

[rtl/dtq_out_if.sv]
`default_nettype none

interface dtq_out_if import dtq_pkg::*; #(
  parameter int TIME_BITS = 63
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [ID_BITS-1:0]   result_id;
  logic                 result_clock;
  logic [TIME_BITS-1:0] remaining;
  logic                 fired;
  logic                 last;

  modport source (
    output valid, status, result_id, result_clock, remaining, fired, last,
    input  ready
  );
  modport sink (
    input  valid, status, result_id, result_clock, remaining, fired, last,
    output ready
  );
endinterface

`default_nettype wire

[rtl/deadline_timer_queue_top.sv]
// deadline timer queue: two expiry-sorted timer lists, monotonic and realtime
//
// req channel carries one operation per beat: relative add (assigns an id),
// absolute add, cancel by id, or tick. rsp channel returns result beats;
// every operation gives exactly one beat, except a tick, which gives one
// beat per fired timer (last marks the final one) or none if nothing is due.
//
// each list is a row of cells; an insert or a removal moves the cells at and
// behind its position in the same clock, each taking its neighbor's entry
// (a tick moves every cell). work runs one operation at a time and req.ready
// is high only while idle. an add passes through the prep and exec states, a
// cancel through prep, the cancel pick and the delete state, a tick through
// prep and then the tick state, which loads the fired timers one after another
// into the output register. the prep state registers the adder and id compare
// results, the cancel pick state the chosen cell and its expiry. the next req
// beat is taken once the sequencer is back in idle.
//
// reset empties both lists and clears the id counter; no clearing pass.
// when rsp stalls, the held result beat waits in the output register and
// the sequencer waits with it before producing the next beat.
`default_nettype none

module deadline_timer_queue_top import dtq_pkg::*; #(
  parameter int TIMERS_PER_QUEUE = 16,
  parameter int TIME_BITS        = 63
) (
  input  logic      clk,
  input  logic      rst,
  dtq_in_if.sink    req,
  dtq_out_if.source rsp
);

  localparam int N  = TIMERS_PER_QUEUE;
  localparam int CW = $clog2(TIMERS_PER_QUEUE + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_CFIND = 3'd3;
  localparam logic [2:0] S_CDEL  = 3'd4;
  localparam logic [2:0] S_TICK  = 3'd5;

  logic [2:0] state, state_next;

  // latched operation
  logic [1:0]           func;
  logic                 clock_sel;
  logic [TIME_BITS-1:0] deadline;
  logic [ID_BITS-1:0]   timer_id;
  logic [TIME_BITS-1:0] now_mono;
  logic [TIME_BITS-1:0] now_real;

  // prep results
  logic [TIME_BITS-1:0] add_expiry;
  logic                 past;
  logic [N-1:0]         match_m, match_r;

  // cancel pick results
  logic                 sel_q;
  logic                 found;
  logic [N-1:0]         del_mask;
  logic [TIME_BITS-1:0] sel_expiry;

  logic [ID_BITS-1:0] id_counter, id_counter_next;
  logic [KW-1:0]      kcnt, kcnt_next;

  // output register
  logic                 out_valid;
  logic [1:0]           out_status;
  logic [ID_BITS-1:0]   out_id;
  logic                 out_clock;
  logic [TIME_BITS-1:0] out_rem;
  logic                 out_fired;
  logic                 out_last;

  // result being produced this cycle
  logic                 emit;
  logic [1:0]           e_status;
  logic [ID_BITS-1:0]   e_id;
  logic                 e_clock;
  logic [TIME_BITS-1:0] e_rem;
  logic                 e_fired;
  logic                 e_last;

  // list interfaces
  dtq_cmd_t             cmd_m, cmd_r;
  logic [N-1:0]         qmask;
  logic [N-1:0]         qmatch_m, qmatch_r;
  logic [N-1:0]         first_m, first_r, oh_next, mask_next;
  logic [TIME_BITS-1:0] selexp_m, selexp_r;
  logic [TIME_BITS-1:0] head_m, head_r, next_m, next_r;
  logic [ID_BITS-1:0]   hid_m, hid_r;
  logic [CW-1:0]        cnt_m, cnt_r;

  logic [TIME_BITS-1:0] now_sel, now_c, new_expiry_next;
  logic [TIME_BITS:0]   sum;
  logic [ID_BITS-1:0]   id_inc, new_id;
  logic                 slot_free, full, any_m, any_r;
  logic                 due_m, due_r, more_m, more_r;

  assign req.ready = (state == S_IDLE);
  assign slot_free = !out_valid || rsp.ready;

  assign now_sel = clock_sel ? now_real : now_mono;
  assign now_c   = sel_q ? now_real : now_mono;

  // relative expiry saturates at the largest time
  assign sum = {1'b0, now_sel} + {1'b0, deadline};
  assign new_expiry_next = (func == FUNC_ADD_REL) ?
                           (sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0]) : deadline;

  // id counter skips zero on wrap
  assign id_inc = (id_counter == '1) ? ID_BITS'(1) : id_counter + ID_BITS'(1);
  assign new_id = (func == FUNC_ADD_REL) ? id_inc : '0;

  assign full = clock_sel ? (cnt_r == CW'(N)) : (cnt_m == CW'(N));

  // heads due strictly before now, with one-entry lookahead for last
  assign due_m  = (cnt_m != '0) && (now_mono > head_m);
  assign due_r  = (cnt_r != '0) && (now_real > head_r);
  assign more_m = (cnt_m > CW'(1)) && (now_mono > next_m);
  assign more_r = (cnt_r > CW'(1)) && (now_real > next_r);

  // cancel: first matching cell, monotonic list before realtime
  assign any_m = |match_m;
  assign any_r = |match_r;
  for (genvar i = 0; i < N; i++) begin : g_pick
    if (i == 0) begin : g_first
      assign first_m[i] = match_m[i];
      assign first_r[i] = match_r[i];
    end else begin : g_rest
      assign first_m[i] = match_m[i] & ~(|match_m[i-1:0]);
      assign first_r[i] = match_r[i] & ~(|match_r[i-1:0]);
    end
    // cells at and behind the hit take their right neighbor
    assign mask_next[i] = |oh_next[i:0];
  end
  assign oh_next = any_m ? first_m : first_r;

  // a tick pops the head, so every cell shifts
  assign qmask = (state == S_TICK) ? '1 : del_mask;

  dtq_queue #(
    .TIMERS_PER_QUEUE(TIMERS_PER_QUEUE),
    .TIME_BITS       (TIME_BITS)
  ) u_mono (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_m),
    .del_mask   (qmask),
    .new_expiry (add_expiry),
    .new_id     (new_id),
    .match_id   (timer_id),
    .sel        (first_m),
    .match      (qmatch_m),
    .sel_expiry (selexp_m),
    .head_expiry(head_m),
    .head_id    (hid_m),
    .next_expiry(next_m),
    .count      (cnt_m)
  );

  dtq_queue #(
    .TIMERS_PER_QUEUE(TIMERS_PER_QUEUE),
    .TIME_BITS       (TIME_BITS)
  ) u_real (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_r),
    .del_mask   (qmask),
    .new_expiry (add_expiry),
    .new_id     (new_id),
    .match_id   (timer_id),
    .sel        (first_r),
    .match      (qmatch_r),
    .sel_expiry (selexp_r),
    .head_expiry(head_r),
    .head_id    (hid_r),
    .next_expiry(next_r),
    .count      (cnt_r)
  );

  // sequencer and result formation
  always_comb begin
    state_next      = state;
    id_counter_next = id_counter;
    kcnt_next       = kcnt;
    cmd_m           = '0;
    cmd_r           = '0;
    emit            = 1'b0;
    e_status        = STAT_OK;
    e_id            = '0;
    e_clock         = 1'b0;
    e_rem           = '0;
    e_fired         = 1'b0;
    e_last          = 1'b1;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        case (func)
          FUNC_TICK:   state_next = S_TICK;
          FUNC_CANCEL: state_next = S_CFIND;
          default:     state_next = S_EXEC;
        endcase
      end
      S_EXEC: begin
        if (slot_free) begin
          emit       = 1'b1;
          e_clock    = clock_sel;
          state_next = S_IDLE;
          if ((func == FUNC_ADD_ABS) && past) begin
            e_status = STAT_PAST;
          end else if (full) begin
            e_status = STAT_FULL;
          end else begin
            cmd_m.ins = !clock_sel;
            cmd_r.ins = clock_sel;
            if (func == FUNC_ADD_REL) begin
              id_counter_next = id_inc;
              e_id            = id_inc;
            end
          end
        end
      end
      S_CFIND: begin
        state_next = S_CDEL;
      end
      S_CDEL: begin
        if (slot_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (found) begin
            e_id      = timer_id;
            e_clock   = sel_q;
            e_rem     = (sel_expiry > now_c) ? sel_expiry - now_c : '0;
            cmd_m.del = !sel_q;
            cmd_r.del = sel_q;
          end else begin
            e_status = STAT_NOT_FOUND;
          end
        end
      end
      S_TICK: begin
        if (slot_free) begin
          if (due_m) begin
            emit      = 1'b1;
            e_fired   = 1'b1;
            e_id      = hid_m;
            e_last    = (kcnt == KW'(MAX_OUT - 1)) || !(more_m || due_r);
            cmd_m.del = 1'b1;
          end else if (due_r) begin
            emit      = 1'b1;
            e_fired   = 1'b1;
            e_id      = hid_r;
            e_clock   = 1'b1;
            e_last    = (kcnt == KW'(MAX_OUT - 1)) || !more_r;
            cmd_r.del = 1'b1;
          end
          if (!emit || e_last) begin
            state_next = S_IDLE;
          end
          kcnt_next = kcnt + KW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      id_counter <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      id_counter <= id_counter_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      func      <= req.func;
      clock_sel <= req.clock_sel;
      deadline  <= req.deadline;
      timer_id  <= req.timer_id;
      now_mono  <= req.now_mono;
      now_real  <= req.now_real;
      kcnt      <= '0;
    end else begin
      kcnt <= kcnt_next;
    end
    if (state == S_PREP) begin
      add_expiry <= new_expiry_next;
      past       <= (deadline <= now_sel);
      match_m    <= qmatch_m;
      match_r    <= qmatch_r;
    end
    if (state == S_CFIND) begin
      sel_q      <= !any_m;
      found      <= any_m || any_r;
      del_mask   <= mask_next;
      sel_expiry <= any_m ? selexp_m : selexp_r;
    end
    if (emit) begin
      out_status <= e_status;
      out_id     <= e_id;
      out_clock  <= e_clock;
      out_rem    <= e_rem;
      out_fired  <= e_fired;
      out_last   <= e_last;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.result_id    = out_id;
  assign rsp.result_clock = out_clock;
  assign rsp.remaining    = out_rem;
  assign rsp.fired        = out_fired;
  assign rsp.last         = out_last;

  // never insert into a full list
  a_ins_not_full: assert property (@(posedge clk) disable iff (rst)
    (cmd_m.ins |-> cnt_m < CW'(N)) and (cmd_r.ins |-> cnt_r < CW'(N)))
    else $error("insert into a full list");

  // at most one list changes per cycle
  a_one_list: assert property (@(posedge clk) disable iff (rst)
    !((cmd_m.ins || cmd_m.del) && (cmd_r.ins || cmd_r.del)))
    else $error("both lists changed in one cycle");

  // every removal is reported by a result beat
  a_del_reported: assert property (@(posedge clk) disable iff (rst)
    (cmd_m.del || cmd_r.del) |-> emit)
    else $error("entry removed without a result");

  // a successful relative add leaves a nonzero id counter
  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    (emit && (state == S_EXEC) && (func == FUNC_ADD_REL) && (e_status == STAT_OK))
      |=> (id_counter != '0))
    else $error("id counter is zero after an add");

endmodule

`default_nettype wire

[rtl/dtq_cell.sv]
`default_nettype none

module dtq_cell import dtq_pkg::*; #(
  parameter int TIME_BITS = 63
) (
  input  logic                 clk,
  input  dtq_cmd_t             cmd,
  input  logic                 occupied,
  input  logic                 left_stays,
  input  logic                 take_right,
  input  logic [TIME_BITS-1:0] new_expiry,
  input  logic [ID_BITS-1:0]   new_id,
  input  logic [TIME_BITS-1:0] left_expiry,
  input  logic [ID_BITS-1:0]   left_id,
  input  logic [TIME_BITS-1:0] right_expiry,
  input  logic [ID_BITS-1:0]   right_id,
  input  logic [ID_BITS-1:0]   match_id,
  output logic [TIME_BITS-1:0] expiry,
  output logic [ID_BITS-1:0]   id,
  output logic                 stays,
  output logic                 match
);

  // equal expiry stays ahead of the newcomer, so ties keep arrival order
  assign stays = occupied && (expiry <= new_expiry);
  assign match = occupied && (id == match_id) && (match_id != '0);

  always_ff @(posedge clk) begin
    if (cmd.ins && !stays) begin
      if (left_stays) begin
        expiry <= new_expiry;
        id     <= new_id;
      end else begin
        expiry <= left_expiry;
        id     <= left_id;
      end
    end else if (cmd.del && take_right) begin
      expiry <= right_expiry;
      id     <= right_id;
    end
  end

endmodule

`default_nettype wire

[rtl/dtq_queue.sv]
`default_nettype none

module dtq_queue import dtq_pkg::*; #(
  parameter int TIMERS_PER_QUEUE = 16,
  parameter int TIME_BITS        = 63,
  localparam int N               = TIMERS_PER_QUEUE,
  localparam int CW              = $clog2(TIMERS_PER_QUEUE + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dtq_cmd_t             cmd,
  input  logic [N-1:0]         del_mask,
  input  logic [TIME_BITS-1:0] new_expiry,
  input  logic [ID_BITS-1:0]   new_id,
  input  logic [ID_BITS-1:0]   match_id,
  input  logic [N-1:0]         sel,
  output logic [N-1:0]         match,
  output logic [TIME_BITS-1:0] sel_expiry,
  output logic [TIME_BITS-1:0] head_expiry,
  output logic [ID_BITS-1:0]   head_id,
  output logic [TIME_BITS-1:0] next_expiry,
  output logic [CW-1:0]        count
);

  logic [TIME_BITS-1:0] cexp  [N];
  logic [ID_BITS-1:0]   cid   [N];
  logic [N-1:0]         stays;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                 lstay;
    logic [TIME_BITS-1:0] lexp, rexp;
    logic [ID_BITS-1:0]   lid, rid;

    if (i == 0) begin : g_head
      assign lstay = 1'b1;
      assign lexp  = new_expiry;
      assign lid   = new_id;
    end else begin : g_body
      assign lstay = stays[i-1];
      assign lexp  = cexp[i-1];
      assign lid   = cid[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign rexp = cexp[i];
      assign rid  = cid[i];
    end else begin : g_inner
      assign rexp = cexp[i+1];
      assign rid  = cid[i+1];
    end

    dtq_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (CW'(i) < count),
      .left_stays  (lstay),
      .take_right  (del_mask[i]),
      .new_expiry  (new_expiry),
      .new_id      (new_id),
      .left_expiry (lexp),
      .left_id     (lid),
      .right_expiry(rexp),
      .right_id    (rid),
      .match_id    (match_id),
      .expiry      (cexp[i]),
      .id          (cid[i]),
      .stays       (stays[i]),
      .match       (match[i])
    );
  end

  // one-hot pick of a cell expiry
  always_comb begin
    sel_expiry = '0;
    for (int i = 0; i < N; i++) begin
      sel_expiry = sel_expiry | (sel[i] ? cexp[i] : '0);
    end
  end

  assign head_expiry = cexp[0];
  assign head_id     = cid[0];

  if (N > 1) begin : g_next
    assign next_expiry = cexp[1];
  end else begin : g_single
    assign next_expiry = cexp[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins) begin
      count <= count + CW'(1);
    end else if (cmd.del) begin
      count <= count - CW'(1);
    end
  end

endmodule

`default_nettype wire

[test/dtq_checker.sv]
`default_nettype none

module dtq_checker import dtq_pkg::*; #(
  parameter int TIMERS_PER_QUEUE = 16,
  parameter int TIME_BITS        = 63
) (
  input  logic clk,
  input  logic rst,
  dtq_in_if    req,
  dtq_out_if   rsp,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [TIME_BITS-1:0] ns_t;
  typedef logic [ID_BITS-1:0]   tid_t;

  typedef struct packed {
    logic [1:0] func;
    logic       sel;
    ns_t        deadline;
    tid_t       tid;
    ns_t        now_mono;
    ns_t        now_real;
  } timer_op_t;

  typedef struct packed {
    logic [1:0] status;
    tid_t       id;
    logic       clock;
    ns_t        remaining;
    logic       fired;
    logic       last;
  } outcome_t;

  // shadow copy of both sorted lists
  ns_t      expiry_tab [2][TIMERS_PER_QUEUE];
  tid_t     owner_tab  [2][TIMERS_PER_QUEUE];
  int       fill       [2];
  tid_t     id_seq;
  outcome_t outcome_q  [$];

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch on %s at %0t: got %0h, want %0h", what, $time, got, want);
    errors++;
  endtask

  function automatic outcome_t make_outcome(input logic [1:0] status, input tid_t id,
                                            input logic clock, input ns_t remaining,
                                            input logic fired, input logic last);
    outcome_t o;
    o.status    = status;
    o.id        = id;
    o.clock     = clock;
    o.remaining = remaining;
    o.fired     = fired;
    o.last      = last;
    return o;
  endfunction

  // ties go behind existing entries of equal expiry
  task automatic insert_timer(input int q, input ns_t e, input tid_t id);
    int pos;
    pos = 0;
    while (pos < fill[q] && expiry_tab[q][pos] <= e) pos++;
    for (int i = fill[q]; i > pos; i--) begin
      expiry_tab[q][i] = expiry_tab[q][i-1];
      owner_tab[q][i]  = owner_tab[q][i-1];
    end
    expiry_tab[q][pos] = e;
    owner_tab[q][pos]  = id;
    fill[q]++;
  endtask

  task automatic drop_timer(input int q, input int pos);
    for (int i = pos; i < fill[q] - 1; i++) begin
      expiry_tab[q][i] = expiry_tab[q][i+1];
      owner_tab[q][i]  = owner_tab[q][i+1];
    end
    fill[q]--;
  endtask

  // works out the result beats of one operation and queues them
  task automatic predict_op(input timer_op_t op);
    ns_t              now_t [2];
    int               q;
    logic [TIME_BITS:0] sum;
    ns_t              e;
    tid_t             id;
    outcome_t         held;
    bit               have;
    bit               found;
    int               k;
    int               hit_q;
    int               hit_i;
    now_t[0] = op.now_mono;
    now_t[1] = op.now_real;
    q        = op.sel;
    case (op.func)
      FUNC_ADD_REL: begin
        sum = {1'b0, now_t[q]} + {1'b0, op.deadline};
        e   = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        if (fill[q] >= TIMERS_PER_QUEUE) begin
          outcome_q.push_back(make_outcome(STAT_FULL, '0, op.sel, '0, 1'b0, 1'b1));
        end else begin
          id = id_seq + 1'b1;
          if (id == '0) id = tid_t'(1);
          id_seq = id;
          insert_timer(q, e, id);
          outcome_q.push_back(make_outcome(STAT_OK, id, op.sel, '0, 1'b0, 1'b1));
        end
      end
      FUNC_ADD_ABS: begin
        if (op.deadline <= now_t[q]) begin
          outcome_q.push_back(make_outcome(STAT_PAST, '0, op.sel, '0, 1'b0, 1'b1));
        end else if (fill[q] >= TIMERS_PER_QUEUE) begin
          outcome_q.push_back(make_outcome(STAT_FULL, '0, op.sel, '0, 1'b0, 1'b1));
        end else begin
          insert_timer(q, op.deadline, '0);
          outcome_q.push_back(make_outcome(STAT_OK, '0, op.sel, '0, 1'b0, 1'b1));
        end
      end
      FUNC_CANCEL: begin
        found = 1'b0;
        hit_q = 0;
        hit_i = 0;
        if (op.tid != '0) begin
          for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < fill[c]; i++) begin
              if (!found && owner_tab[c][i] == op.tid) begin
                found = 1'b1;
                hit_q = c;
                hit_i = i;
              end
            end
          end
        end
        if (found) begin
          e = expiry_tab[hit_q][hit_i];
          drop_timer(hit_q, hit_i);
          outcome_q.push_back(make_outcome(STAT_OK, op.tid, 1'(hit_q),
                                           (e > now_t[hit_q]) ? e - now_t[hit_q] : ns_t'(0),
                                           1'b0, 1'b1));
        end else begin
          outcome_q.push_back(make_outcome(STAT_NOT_FOUND, '0, 1'b0, '0, 1'b0, 1'b1));
        end
      end
      default: begin
        // tick: monotonic heads first, last flag on the final beat only
        have = 1'b0;
        k    = 0;
        for (int c = 0; c < 2; c++) begin
          while (k < MAX_OUT && fill[c] > 0 && now_t[c] > expiry_tab[c][0]) begin
            if (have) outcome_q.push_back(held);
            held = make_outcome(STAT_OK, owner_tab[c][0], 1'(c), '0, 1'b1, 1'b0);
            have = 1'b1;
            drop_timer(c, 0);
            k++;
          end
        end
        if (have) begin
          held.last = 1'b1;
          outcome_q.push_back(held);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    timer_op_t op;
    outcome_t  want;
    if (rst) begin
      fill[0] = 0;
      fill[1] = 0;
      id_seq  = '0;
      outcome_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (outcome_q.size() == 0) begin
          flag_mismatch("result beat with nothing pending", 64'(rsp.result_id), 64'd0);
        end else begin
          want = outcome_q.pop_front();
          if (rsp.status !== want.status)
            flag_mismatch("status", 64'(rsp.status), 64'(want.status));
          if (rsp.result_id !== want.id)
            flag_mismatch("result_id", 64'(rsp.result_id), 64'(want.id));
          if (rsp.result_clock !== want.clock)
            flag_mismatch("result_clock", 64'(rsp.result_clock), 64'(want.clock));
          if (rsp.remaining !== want.remaining)
            flag_mismatch("remaining", 64'(rsp.remaining), 64'(want.remaining));
          if (rsp.fired !== want.fired)
            flag_mismatch("fired", 64'(rsp.fired), 64'(want.fired));
          if (rsp.last !== want.last)
            flag_mismatch("last", 64'(rsp.last), 64'(want.last));
        end
      end
      if (req.valid && req.ready) begin
        op.func     = req.func;
        op.sel      = req.clock_sel;
        op.deadline = req.deadline;
        op.tid      = req.timer_id;
        op.now_mono = req.now_mono;
        op.now_real = req.now_real;
        predict_op(op);
      end
    end
    pending = outcome_q.size();
  end

endmodule

`default_nettype wire

[test/tb_top.sv]
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dtq_pkg::*;

  localparam int TPQ   = 16;
  localparam int TB    = 63;
  // longest run of cycles with no beat on either side before giving up
  localparam int LIMIT = 4000;

  typedef logic [TB-1:0]      ns_t;
  typedef logic [ID_BITS-1:0] tid_t;

  localparam ns_t T_MAX = '1;

  logic clk = 1'b0;
  logic rst;

  // handshake between the stimulus and the response side
  bit hold_req = 1'b0;   // ask the receiver for one long hold-off
  bit steady   = 1'b0;   // no idling on either side while set
  int rel_sent = 0;      // relative adds offered, bounds the ids worth cancelling
  int errors;
  int pending;
  int quiet;

  dtq_in_if  #(.TIME_BITS(TB)) req_if ();
  dtq_out_if #(.TIME_BITS(TB)) rsp_if ();

  deadline_timer_queue_top #(
    .TIMERS_PER_QUEUE(TPQ),
    .TIME_BITS       (TB)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  dtq_checker #(
    .TIMERS_PER_QUEUE(TPQ),
    .TIME_BITS       (TB)
  ) i_checker (
    .clk    (clk),
    .rst    (rst),
    .req    (req_if),
    .rsp    (rsp_if),
    .errors (errors),
    .pending(pending)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // full-width random time, reaches the top bits of every time field
  function automatic ns_t any_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TB-1:0];
  endfunction

  // one request beat; entered and left at a falling edge, valid stays high on
  // return so a back-to-back beat never lowers and raises it in one step
  task automatic offer(input logic [1:0] op, input logic sel, input ns_t dl,
                       input tid_t tid, input ns_t nm, input ns_t nr);
    if (!steady) begin
      while ($urandom_range(0, 99) < 29) begin
        req_if.valid <= 1'b0;
        @(negedge clk);
      end
    end
    req_if.valid     <= 1'b1;
    req_if.func      <= op;
    req_if.clock_sel <= sel;
    req_if.deadline  <= dl;
    req_if.timer_id  <= tid;
    req_if.now_mono  <= nm;
    req_if.now_real  <= nr;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
    if (op == FUNC_ADD_REL) rel_sent++;
  endtask

  // park the request side until every predicted beat has come back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // response side: random stalls, one long hold-off on request
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      rsp_if.ready <= steady || ($urandom_range(0, 99) >= 29);
    end
  end

  // hang detector: cycles with no beat accepted on either channel
  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    ns_t  now_m;
    ns_t  now_r;
    ns_t  tq;
    ns_t  dl;
    tid_t tid;
    int   pick;
    int   span;
    logic sel;

    rst              = 1'b1;
    req_if.valid     = 1'b0;
    req_if.func      = FUNC_ADD_REL;
    req_if.clock_sel = 1'b0;
    req_if.deadline  = '0;
    req_if.timer_id  = '0;
    req_if.now_mono  = '0;
    req_if.now_real  = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed beats ----
    // tick on empty lists gives no result beat at all
    offer(FUNC_TICK, 1'b0, '0, '0, 63'd1000, 63'd1000);
    // id 0 never matches, unknown id neither
    offer(FUNC_CANCEL, 1'b0, '0, '0, 63'd0, 63'd0);
    offer(FUNC_CANCEL, 1'b1, '0, 32'd7, 63'd0, 63'd0);
    // relative adds: zero delay, saturating sum, realtime list
    offer(FUNC_ADD_REL, 1'b0, 63'd0, '0, 63'd100, 63'd0);          // id 1, due 100
    offer(FUNC_ADD_REL, 1'b0, T_MAX, '0, T_MAX, 63'd0);            // id 2, due at max
    offer(FUNC_ADD_REL, 1'b1, 63'd10, '0, 63'd0, 63'd50);          // id 3, due 60
    // absolute adds: deadline equal to now and zero are already past
    offer(FUNC_ADD_ABS, 1'b0, 63'd100, '0, 63'd100, 63'd0);
    offer(FUNC_ADD_ABS, 1'b1, 63'd0, '0, 63'd0, 63'd0);
    offer(FUNC_ADD_ABS, 1'b1, 63'd1000, '0, 63'd0, 63'd50);
    offer(FUNC_ADD_ABS, 1'b0, T_MAX, '0, 63'd0, 63'd0);            // never fires
    // equal expiry keeps arrival order behind id 1
    offer(FUNC_ADD_REL, 1'b0, 63'd20, '0, 63'd80, 63'd0);          // id 4, due 100
    offer(FUNC_ADD_REL, 1'b0, 63'd100, '0, 63'd0, 63'd0);          // id 5, due 100
    // cancel found only after the monotonic search, with time left
    offer(FUNC_CANCEL, 1'b0, '0, 32'd3, 63'd0, 63'd40);
    // cancel of a timer already due reports nothing left
    offer(FUNC_CANCEL, 1'b0, '0, 32'd4, 63'd500, 63'd0);
    offer(FUNC_ADD_REL, 1'b1, 63'd5, '0, 63'd0, 63'd0);            // id 6, due 5
    // fires ids 1 and 5 then 6; the next tick at equal times fires nothing
    offer(FUNC_TICK, 1'b0, '0, '0, 63'd101, 63'd6);
    offer(FUNC_TICK, 1'b1, '0, '0, 63'd100, 63'd0);
    offer(FUNC_CANCEL, 1'b0, '0, 32'd2, 63'd0, 63'd0);             // all time left
    offer(FUNC_CANCEL, 1'b1, '0, 32'hffff_ffff, T_MAX, T_MAX);
    // clears the realtime list; the max-expiry absolute timer stays
    offer(FUNC_TICK, 1'b0, '0, '0, T_MAX, T_MAX);

    // ---- back-pressure: fill both lists while results are held off ----
    hold_req = 1'b1;
    for (int i = 0; i < 17; i++)
      offer(FUNC_ADD_REL, 1'b1, ns_t'($urandom_range(0, 50)), '0, 63'd5000, 63'd5000);
    // full list: the past check wins over the full check
    offer(FUNC_ADD_ABS, 1'b1, 63'd5000, '0, 63'd5000, 63'd5000);
    offer(FUNC_ADD_ABS, 1'b1, 63'd9000, '0, 63'd5000, 63'd5000);
    for (int i = 0; i < 16; i++)
      offer(FUNC_ADD_REL, 1'b0, ns_t'($urandom_range(0, 50)), '0, 63'd5000, 63'd5000);
    // one tick that empties everything it can, a burst of beats
    offer(FUNC_TICK, 1'b0, '0, '0, T_MAX, T_MAX);
    drain_results();

    // ---- random traffic ----
    now_m = {5'd0, 26'($urandom_range(0, (1 << 26) - 1)), 32'($urandom)};
    now_r = {5'd0, 26'($urandom_range(0, (1 << 26) - 1)), 32'($urandom)};
    for (int n = 0; n < 420; n++) begin
      // long stretch with no idling on either side
      steady = (n >= 220 && n < 300);
      // sender waits for the block to go quiet once mid-run
      if (n == 140) drain_results();

      now_m += ns_t'($urandom_range(0, 40));
      now_r += ns_t'($urandom_range(0, 40));
      sel   = 1'($urandom_range(0, 1));
      tq    = sel ? now_r : now_m;
      pick  = $urandom_range(0, 99);

      if (pick < 8) begin
        // noise: every field at full width
        offer(2'($urandom_range(0, 3)), sel, any_time(), tid_t'($urandom),
              any_time(), any_time());
      end else if (pick < 11) begin
        // sweep tick, fires all but timers due at the largest time
        offer(FUNC_TICK, sel, '0, '0, T_MAX, T_MAX);
      end else if (pick < 43) begin
        offer(FUNC_ADD_REL, sel, ns_t'($urandom_range(0, 400)), '0, now_m, now_r);
      end else if (pick < 58) begin
        // mostly ahead of now, sometimes at or behind it
        dl = tq + ns_t'($urandom_range(0, 400)) - ns_t'($urandom_range(0, 60));
        offer(FUNC_ADD_ABS, sel, dl, '0, now_m, now_r);
      end else if (pick < 75) begin
        // mostly recently issued ids, some live, some gone
        case ($urandom_range(0, 9))
          0:       tid = '0;
          1:       tid = tid_t'($urandom);
          default: begin
            span = (rel_sent < 12) ? rel_sent : 12;
            tid  = tid_t'(rel_sent + 1 - $urandom_range(0, span));
          end
        endcase
        offer(FUNC_CANCEL, sel, '0, tid, now_m, now_r);
      end else begin
        // tick, now and then after a jump so several timers fire at once
        if ($urandom_range(0, 3) == 0) begin
          now_m += ns_t'($urandom_range(0, 800));
          now_r += ns_t'($urandom_range(0, 800));
        end
        offer(FUNC_TICK, sel, '0, '0, now_m, now_r);
      end
    end
    steady = 1'b0;

    // wind down: all beats back, then idle so that a stray beat would still be checked
    drain_results();
    repeat (30) @(negedge clk);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/dtq_pkg.sv
rtl/dtq_in_if.sv
rtl/dtq_out_if.sv
rtl/dtq_cell.sv
rtl/dtq_queue.sv
rtl/deadline_timer_queue_top.sv
test/dtq_checker.sv
test/tb_top.sv
